>>> rtl/ubh_pkg.sv
// ----------------------------------------------------------------------------
// ubh_pkg
// shared constants, types and helpers for the uniform bin histogram core
// ----------------------------------------------------------------------------
package ubh_pkg;

  localparam int MAX_SAMPLES_DEF    = 4096;
  localparam int MAX_BINS_DEF       = 64;
  localparam int EDGE_FRAC_BITS_DEF = 8;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 32;
  localparam int CNT_W    = 13;
  localparam int IDX_W    = 6;
  localparam int EDGE_W   = 42;
  localparam int NB_W     = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    REG_NUM_BINS   = 2'd0,
    REG_USE_FIXED  = 2'd1,
    REG_RANGE_LOW  = 2'd2,
    REG_RANGE_HIGH = 2'd3
  } reg_idx_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

>>> rtl/ubh_if.sv
// ----------------------------------------------------------------------------
// ubh_in_if / ubh_out_if
// valid/ready channels for samples and bin results
// ----------------------------------------------------------------------------
interface ubh_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ubh_pkg::SAMPLE_W-1:0] sample;
  logic                              final_sample;
  modport source (output valid, sample, final_sample, input ready);
  modport sink (input valid, sample, final_sample, output ready);
endinterface

interface ubh_out_if;
  logic                                valid;
  logic                                ready;
  logic [ubh_pkg::IDX_W-1:0]           bin_index;
  logic signed [ubh_pkg::EDGE_W-1:0]   bin_upper_edge;
  logic [ubh_pkg::CNT_W-1:0]           bin_count;
  logic [ubh_pkg::CNT_W-1:0]           overflow_count;
  logic                                last_bin;
  modport source (output valid, bin_index, bin_upper_edge, bin_count, overflow_count,
                  last_bin, input ready);
  modport sink (input valid, bin_index, bin_upper_edge, bin_count, overflow_count,
                last_bin, output ready);
endinterface

>>> rtl/ubh_divider.sv
// ----------------------------------------------------------------------------
// ubh_divider
// restoring divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module ubh_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic             rem_nz
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   r;
  logic [DEN_W-1:0] dv;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;

  assign shifted = {r[DEN_W-1:0], q[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q  <= num;
      r  <= '0;
      dv <= den;
    end else if (busy) begin
      if (shifted >= {1'b0, dv}) begin
        r <= shifted - {1'b0, dv};
        q <= {q[NUM_W-2:0], 1'b1};
      end else begin
        r <= shifted;
        q <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot   = q;
  assign rem_nz = (r != '0);

endmodule

>>> rtl/uniform_bin_histogram_core.sv
// ----------------------------------------------------------------------------
// uniform_bin_histogram_core
// stores a sample set, bins it into equal-width bins, reports one result per bin
// ----------------------------------------------------------------------------
//  channel  dir  payload                                      handshake
//  cfg      in   cfg_we, cfg_index, cfg_data                  write on cfg_we
//  in       in   sample, final_sample                         valid/ready
//  out      out  bin_index, upper edge, count, overflow, last valid/ready
//
//  a non-final sample is stored as it is taken, back to back, while the store has room
//  on the final sample each stored sample is binned by a serial divider
//  (64-bit quotient, one bit per cycle), unless one bin or a range width <= 0 is used
//  each bin edge takes another divide
//  bin counters live in a MAX_BINS-entry memory cleared one entry per cycle at
//  the end of a set and after reset, input stalls meanwhile
// ----------------------------------------------------------------------------
module uniform_bin_histogram_core #(
  parameter int MAX_SAMPLES    = ubh_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_BINS       = ubh_pkg::MAX_BINS_DEF,
  parameter int EDGE_FRAC_BITS = ubh_pkg::EDGE_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [ubh_pkg::CFG_W-1:0] cfg_data,
  ubh_in_if.sink                   in_ch,
  ubh_out_if.source                out_ch
);

  localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SCW = $clog2(MAX_SAMPLES + 1);
  localparam int BW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NW  = 64;
  localparam int DW  = 34;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_UPD   = 7'b0010000,
    S_EDGE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [ubh_pkg::NB_W-1:0]       num_bins;
  logic                           use_fixed;
  logic signed [31:0]             range_low, range_high;

  logic signed [31:0]             sample_mem [MAX_SAMPLES];
  logic [ubh_pkg::CNT_W-1:0]      bin_mem [MAX_BINS];
  logic signed [31:0]             smp_rd;
  logic [ubh_pkg::CNT_W-1:0]      bin_rd;

  logic [SCW-1:0]                 stored;
  logic [SCW-1:0]                 ptr;
  logic signed [31:0]             run_min, run_max;
  logic [ubh_pkg::CNT_W-1:0]      ovf;
  logic [BW-1:0]                  bidx;
  logic [BW:0]                    nb;
  logic signed [34:0]             lo, d;
  logic                           div_start, div_done, div_rnz;
  logic [NW-1:0]                  div_num, div_q;
  logic                           neg;
  logic [BW-1:0]                  tgt;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins   <= ubh_pkg::NB_W'(1);
      use_fixed  <= 1'b0;
      range_low  <= '0;
      range_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ubh_pkg::REG_NUM_BINS:   num_bins   <= cfg_data[ubh_pkg::NB_W-1:0];
        ubh_pkg::REG_USE_FIXED:  use_fixed  <= cfg_data[0];
        ubh_pkg::REG_RANGE_LOW:  range_low  <= cfg_data;
        ubh_pkg::REG_RANGE_HIGH: range_high <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [BW:0] nb_sel;
  always_comb begin
    if (num_bins == '0) nb_sel = (BW+1)'(1);
    else if (32'(num_bins) > MAX_BINS) nb_sel = (BW+1)'(MAX_BINS);
    else nb_sel = (BW+1)'(num_bins);
  end

  logic acc;
  logic room;
  assign in_ch.ready = (state == S_LOAD);
  assign acc  = in_ch.valid && in_ch.ready;
  assign room = (stored < SCW'(MAX_SAMPLES));

  always_ff @(posedge clk) begin
    if (acc && room) sample_mem[stored[AW-1:0]] <= in_ch.sample;
    smp_rd <= sample_mem[ptr[AW-1:0]];
  end

  // bin arithmetic operands
  logic signed [35:0] x_lo;
  logic signed [42:0] prod;
  logic signed [42:0] lo_n, d_i;
  logic signed [63:0] enum_s;
  assign x_lo = 36'(smp_rd) - 36'(lo);
  assign prod = 43'(x_lo) * 43'($signed({1'b0, nb}));
  assign lo_n = 43'(lo) * 43'($signed({1'b0, nb}));
  assign d_i  = 43'(d) * 43'($signed({1'b0, 7'(bidx) + 7'd1}));
  assign enum_s = (64'(lo_n) + 64'(d_i)) <<< EDGE_FRAC_BITS;

  logic signed [63:0] nsel;
  assign nsel = (state == S_EDGE) ? enum_s : 64'(prod);

  ubh_divider #(.NUM_W(NW), .DEN_W(DW)) u_div (
    .clk, .rst, .start(div_start), .num(div_num),
    .den((state == S_EDGE) ? DW'(nb) : d[DW-1:0]),
    .done(div_done), .quot(div_q), .rem_nz(div_rnz)
  );

  logic signed [64:0] fq;
  assign fq = neg ? -$signed({1'b0, div_q}) - 65'(div_rnz) : $signed({1'b0, div_q});

  logic signed [63:0] numr;
  always_ff @(posedge clk) begin
    if (div_start) neg <= nsel[63];
  end
  assign numr = nsel[63] ? -nsel : nsel;
  always_comb div_num = numr;

  logic [ubh_pkg::CNT_W-1:0] cnt_new;
  logic                      in_bin;
  assign in_bin = !fq[64] && (fq < 65'($signed({1'b0, nb})));

  logic signed [41:0] edge_sat;
  always_comb begin
    if (fq > 65'sd2199023255551) edge_sat = 42'sh1FFFFFFFFFF;
    else if (fq < -65'sd2199023255552) edge_sat = 42'sh20000000000;
    else edge_sat = fq[41:0];
  end

  logic out_v;
  logic ovalid;
  assign out_ch.valid = ovalid;

  // counter read follows the quotient while a divide finishes
  always_ff @(posedge clk) begin
    bin_rd <= bin_mem[(state == S_DIV) ? fq[BW-1:0] : bidx];
    if (state == S_CLEAR) bin_mem[bidx] <= '0;
    else if (state == S_UPD && in_bin) bin_mem[tgt] <= cnt_new;
  end
  assign cnt_new = ubh_pkg::sat_inc(bin_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      bidx      <= '0;
      stored    <= '0;
      ovf       <= '0;
      run_min   <= 32'sh7FFFFFFF;
      run_max   <= 32'sh80000000;
      ovalid    <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_CLEAR: begin
          bidx <= bidx + BW'(1);
          if (32'(bidx) == MAX_BINS - 1) begin
            bidx  <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (acc) begin
            if (room) begin
              stored <= stored + SCW'(1);
              if (in_ch.sample < run_min) run_min <= in_ch.sample;
              if (in_ch.sample > run_max) run_max <= in_ch.sample;
            end else begin
              ovf <= ubh_pkg::sat_inc(ovf);
            end
            if (in_ch.final_sample) begin
              nb  <= nb_sel;
              ptr <= '0;
              if (use_fixed) begin
                lo <= 35'(range_low);
                d  <= 35'(range_high) - 35'(range_low);
              end else begin
                lo <= 35'(in_ch.sample < run_min && room ? in_ch.sample : run_min) - 35'sd1;
                d  <= 35'(in_ch.sample > run_max && room ? in_ch.sample : run_max) -
                      35'(in_ch.sample < run_min && room ? in_ch.sample : run_min) + 35'sd2;
              end
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (nb == (BW+1)'(1) || ptr == stored) begin
            bidx      <= '0;
            state     <= S_EDGE;
            div_start <= 1'b1;
          end else if (d <= 0) begin
            ovf <= ubh_pkg::sat_inc(ovf);
            ptr <= ptr + SCW'(1);
          end else begin
            state     <= S_DIV;
            div_start <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            tgt   <= fq[BW-1:0];
            bidx  <= fq[BW-1:0];
            state <= S_UPD;
            if (!in_bin) ovf <= ubh_pkg::sat_inc(ovf);
          end
        end
        S_UPD: begin
          ptr   <= ptr + SCW'(1);
          state <= S_RD;
        end
        S_EDGE: begin
          if (div_done) begin
            out_ch.bin_index      <= ubh_pkg::IDX_W'(bidx);
            out_ch.bin_upper_edge <= edge_sat;
            out_ch.bin_count      <= (nb == (BW+1)'(1)) ?
                                     ((stored > SCW'(ubh_pkg::CNT_MAX)) ? ubh_pkg::CNT_MAX :
                                      ubh_pkg::CNT_W'(stored)) : bin_rd;
            out_ch.overflow_count <= ovf;
            out_ch.last_bin       <= ((BW+1)'(bidx) + (BW+1)'(1) == nb);
            ovalid <= 1'b1;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            ovalid <= 1'b0;
            if (out_ch.last_bin) begin
              bidx    <= '0;
              stored  <= '0;
              ovf     <= '0;
              run_min <= 32'sh7FFFFFFF;
              run_max <= 32'sh80000000;
              state   <= S_CLEAR;
            end else begin
              bidx      <= bidx + BW'(1);
              div_start <= 1'b1;
              state     <= S_EDGE;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign out_v = ovalid;

  a_out_in_state: assert property (@(posedge clk) disable iff (rst)
    out_v |-> state == S_OUT) else $error("result valid outside output state");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_v) else $error("input taken while results pending");
  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= SCW'(MAX_SAMPLES)) else $error("stored count past store depth");
  a_upd_after_div: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> $past(state) == S_DIV) else $error("update without divide");

endmodule
